>>> sv/tci_pkg.sv
// Shared constants, register codes and fixed-point helpers for the throttle curve interpolator.
// Holds constant dividers as reciprocal estimates with a one-step correction.
// No dependencies.
package tci_pkg;

  localparam int DEFL_W = 10;
  localparam int THR_W  = 11;
  localparam int PCT_W  = 7;
  localparam int CFG_W  = 11;
  localparam int LANES  = 2;
  localparam int NST    = 20;

  localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
  localparam logic [DEFL_W-1:0] FULL_DEFL = 10'd1000;
  localparam logic [3:0]        LAST_SEG  = 4'd9;
  localparam logic [9:0]        CURVE_TOP = 10'd1000;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_CURVE_MID    = 2'd0,
    CFG_CURVE_EXPO   = 2'd1,
    CFG_MIN_THROTTLE = 2'd2,
    CFG_MAX_THROTTLE = 2'd3
  } cfg_idx_t;

  // One restoring division step
  typedef struct packed {
    logic [19:0] rem;
    logic        qbit;
  } div_step_t;

  // Percent values above 100 saturate
  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
    return (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

  // d / 100 for d < 1024, exact through 41/4096
  function automatic logic [3:0] seg_of(input logic [DEFL_W-1:0] d);
    logic [15:0] p;
    p = {6'd0, d} * 16'd41;
    return p[15:12];
  endfunction

  function automatic div_step_t div_step(input logic [19:0] rem, input logic [19:0] dsh);
    div_step_t st;
    st.qbit = (rem >= dsh);
    st.rem  = st.qbit ? (rem - dsh) : rem;
    return st;
  endfunction

  // x / 10, x <= 10000: estimate is exact or one low
  function automatic logic [9:0] div10_est(input logic [13:0] x);
    logic [25:0] p;
    p = {12'd0, x} * 26'd3276;
    return p[24:15];
  endfunction

  function automatic logic [9:0] div10_fix(input logic [13:0] x, input logic [9:0] q0);
    logic [13:0] back;
    logic [13:0] rem;
    back = {4'd0, q0} * 14'd10;
    rem  = x - back;
    return (rem >= 14'd10) ? (q0 + 10'd1) : q0;
  endfunction

  // x / 1000, x < 2048000 so that the quotient fits in 11 bits
  function automatic logic [10:0] div1000_est(input logic [20:0] x);
    logic [32:0] p;
    p = {12'd0, x} * 33'd2097;
    return p[31:21];
  endfunction

  function automatic logic [10:0] div1000_fix(input logic [20:0] x, input logic [10:0] q0);
    logic [20:0] back;
    logic [20:0] rem;
    back = {10'd0, q0} * 21'd1000;
    rem  = x - back;
    return (rem >= 21'd1000) ? (q0 + 11'd1) : q0;
  endfunction

  // x / 100, x < 204800 so that the quotient fits in 11 bits
  function automatic logic [10:0] div100_est(input logic [17:0] x);
    logic [29:0] p;
    p = {12'd0, x} * 30'd2621;
    return p[28:18];
  endfunction

  function automatic logic [10:0] div100_fix(input logic [17:0] x, input logic [10:0] q0);
    logic [17:0] back;
    logic [17:0] rem;
    back = {7'd0, q0} * 18'd100;
    rem  = x - back;
    return (rem >= 18'd100) ? (q0 + 11'd1) : q0;
  endfunction

endpackage

>>> sv/throttle_curve_interpolator_top.sv
// Throttle curve interpolator: stick deflection to throttle through a mid/expo curve.
// Twenty-stage pipeline, two knot lanes; depends on tci_pkg.
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+-----------------------
//   in      | in_deflection                              | in_valid / in_ready
//   out     | out_throttle, out_throttle_mid             | out_valid / out_ready
//   cfg     | cfg_index, cfg_wdata                       | cfg_wr_en, no wait
//
// One item per cycle sustained while the output is not held off.
// The 20 register stages cover squaring, the 7-bit restoring divider (two bits a
// stage, bit 0 alone), three constant dividers and the final interpolation.
// A stalled output holds only the stages behind it up to the first bubble.
// Synchronous active-low reset clears all valid bits and loads the register defaults;
// values derived from the registers settle through the span, product, quotient and mid-point registers.
module throttle_curve_interpolator_top
  import tci_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DEFL_W-1:0] in_deflection,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [THR_W-1:0]  out_throttle,
  output logic [THR_W-1:0]  out_throttle_mid,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // Configuration registers
  logic [PCT_W-1:0] curve_mid_r;
  logic [PCT_W-1:0] curve_expo_r;
  logic [THR_W-1:0] min_thr_r;
  logic [THR_W-1:0] max_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mid_r  <= 7'd50;
      curve_expo_r <= 7'd0;
      min_thr_r    <= 11'd0;
      max_thr_r    <= 11'd2000;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CURVE_MID:    curve_mid_r  <= cfg_wdata[PCT_W-1:0];
        CFG_CURVE_EXPO:   curve_expo_r <= cfg_wdata[PCT_W-1:0];
        CFG_MIN_THROTTLE: min_thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_MAX_THROTTLE: max_thr_r    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PCT_W-1:0] mid_sat;
  logic [PCT_W-1:0] expo_sat;
  assign mid_sat  = sat_pct(curve_mid_r);
  assign expo_sat = sat_pct(curve_expo_r);

  // Span of the limits and the mid-point throttle, free running from the registers
  logic             span_neg_r;
  logic [THR_W-1:0] span_mag_r;
  logic [17:0]      tm_prod_r;
  logic [17:0]      tm_prod_d_r;
  logic [10:0]      tm_q0_r;
  logic [10:0]      tm_q_r;
  logic [THR_W-1:0] tmid_r;

  always_ff @(posedge clk) begin
    span_neg_r  <= (max_thr_r < min_thr_r);
    span_mag_r  <= (max_thr_r < min_thr_r) ? (min_thr_r - max_thr_r) : (max_thr_r - min_thr_r);
    tm_prod_r   <= {7'd0, span_mag_r} * {11'd0, mid_sat};
    tm_prod_d_r <= tm_prod_r;
    tm_q0_r     <= div100_est(tm_prod_r);
    tm_q_r      <= div100_fix(tm_prod_d_r, tm_q0_r);
    tmid_r      <= span_neg_r ? (min_thr_r - tm_q_r) : (min_thr_r + tm_q_r);
  end

  // Stage enables: a stage loads when it is empty or everything ahead moves
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = out_ready || !vld_r[NST-1];
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = en[i+1] || !vld_r[i];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Stage 1 next values: segment, offset, and per knot lane the signed distance to mid
  logic [3:0]       seg_raw;
  logic [3:0]       seg;
  logic [9:0]       seg_x100;
  logic [9:0]       r_full;
  logic [6:0]       s1_mag_nxt [LANES];
  logic             s1_neg_nxt [LANES];
  logic [6:0]       s1_y_nxt   [LANES];

  always_comb begin
    logic [3:0] k;
    logic [6:0] k_x10;
    logic [7:0] tmp;
    logic [7:0] tmp_n;
    seg_raw  = seg_of(in_deflection);
    seg      = (seg_raw > LAST_SEG) ? LAST_SEG : seg_raw;
    seg_x100 = {6'd0, seg} * 10'd100;
    r_full   = in_deflection - seg_x100;
    for (int l = 0; l < LANES; l++) begin
      k     = seg + 4'(l);
      k_x10 = {3'd0, k} * 7'd10;
      tmp   = {1'b0, k_x10} - {1'b0, mid_sat};
      tmp_n = -tmp;
      s1_neg_nxt[l] = tmp[7];
      s1_mag_nxt[l] = tmp[7] ? tmp_n[6:0] : tmp[6:0];
      if (tmp[7]) begin
        s1_y_nxt[l] = mid_sat;
      end else if (tmp == 8'd0) begin
        s1_y_nxt[l] = 7'd1;
      end else begin
        s1_y_nxt[l] = PCT_FULL - mid_sat;
      end
    end
  end

  // Per-lane payload registers
  logic [6:0]  s1_mag_r  [LANES];
  logic        s1_neg_r  [LANES];
  logic [6:0]  s1_y_r    [LANES];
  logic [6:0]  s2_mag_r  [LANES];
  logic        s2_neg_r  [LANES];
  logic [13:0] s2_tsq_r  [LANES];
  logic [13:0] s2_ysq_r  [LANES];
  logic [6:0]  s3_mag_r  [LANES];
  logic        s3_neg_r  [LANES];
  logic [19:0] s3_num_r  [LANES];
  logic [13:0] s3_ysq_r  [LANES];
  logic [6:0]  s4_mag_r  [LANES];
  logic        s4_neg_r  [LANES];
  logic [19:0] s4_rem_r  [LANES];
  logic [6:0]  s4_q_r    [LANES];
  logic [13:0] s4_ysq_r  [LANES];
  logic [6:0]  s5_mag_r  [LANES];
  logic        s5_neg_r  [LANES];
  logic [19:0] s5_rem_r  [LANES];
  logic [6:0]  s5_q_r    [LANES];
  logic [13:0] s5_ysq_r  [LANES];
  logic [6:0]  s6_mag_r  [LANES];
  logic        s6_neg_r  [LANES];
  logic [19:0] s6_rem_r  [LANES];
  logic [6:0]  s6_q_r    [LANES];
  logic [13:0] s6_ysq_r  [LANES];
  logic [6:0]  s7_mag_r  [LANES];
  logic        s7_neg_r  [LANES];
  logic [6:0]  s7_term_r [LANES];
  logic        s8_neg_r  [LANES];
  logic [13:0] s8_prod_r [LANES];
  logic        s9_neg_r  [LANES];
  logic [13:0] s9_prod_r [LANES];
  logic [9:0]  s9_q0_r   [LANES];
  logic        s10_neg_r [LANES];
  logic [9:0]  s10_t_r   [LANES];
  logic [9:0]  s11_c_r   [LANES];
  logic [20:0] s12_kp_r  [LANES];
  logic [20:0] s13_kp_r  [LANES];
  logic [10:0] s13_q0_r  [LANES];
  logic [10:0] s14_kq_r  [LANES];
  logic [THR_W-1:0] s15_knot_r [LANES];

  // Shared item registers
  logic       full_r [16];
  logic [6:0] r_r    [16];

  // Divider and curve-value next values per lane
  logic [19:0] s4_rem_nxt [LANES];
  logic [6:0]  s4_q_nxt   [LANES];
  logic [19:0] s5_rem_nxt [LANES];
  logic [6:0]  s5_q_nxt   [LANES];
  logic [19:0] s6_rem_nxt [LANES];
  logic [6:0]  s6_q_nxt   [LANES];
  logic [6:0]  s7_term_nxt [LANES];
  logic [20:0] s3_num_nxt [LANES];
  logic [9:0]  s11_c_nxt  [LANES];

  always_comb begin
    div_step_t   st_a;
    div_step_t   st_b;
    logic [19:0] d3;
    logic [19:0] d4;
    logic [19:0] d5;
    logic [19:0] d6;
    logic [6:0]  q7;
    logic [10:0] mid10;
    logic [10:0] c11;
    for (int l = 0; l < LANES; l++) begin
      s3_num_nxt[l] = {14'd0, expo_sat} * {7'd0, s2_tsq_r[l]};
      // quotient bits 6 and 5
      d3   = {6'd0, s3_ysq_r[l]};
      st_a = div_step(s3_num_r[l], d3 << 6);
      st_b = div_step(st_a.rem, d3 << 5);
      s4_rem_nxt[l] = st_b.rem;
      s4_q_nxt[l]   = {st_a.qbit, st_b.qbit, 5'd0};
      // bits 4 and 3
      d4   = {6'd0, s4_ysq_r[l]};
      st_a = div_step(s4_rem_r[l], d4 << 4);
      st_b = div_step(st_a.rem, d4 << 3);
      s5_rem_nxt[l] = st_b.rem;
      s5_q_nxt[l]   = s4_q_r[l] | {2'd0, st_a.qbit, st_b.qbit, 3'd0};
      // bits 2 and 1
      d5   = {6'd0, s5_ysq_r[l]};
      st_a = div_step(s5_rem_r[l], d5 << 2);
      st_b = div_step(st_a.rem, d5 << 1);
      s6_rem_nxt[l] = st_b.rem;
      s6_q_nxt[l]   = s5_q_r[l] | {4'd0, st_a.qbit, st_b.qbit, 1'b0};
      // bit 0, then the expo weight
      d6   = {6'd0, s6_ysq_r[l]};
      st_a = div_step(s6_rem_r[l], d6);
      q7   = s6_q_r[l] | {6'd0, st_a.qbit};
      s7_term_nxt[l] = PCT_FULL - expo_sat + q7;
      // curve value around 10 * mid
      mid10 = {4'd0, mid_sat} * 11'd10;
      c11   = s10_neg_r[l] ? (mid10 - {1'b0, s10_t_r[l]}) : (mid10 + {1'b0, s10_t_r[l]});
      s11_c_nxt[l] = c11[9:0];
    end
  end

  // Knot lanes, stages 1 to 15
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (en[0]) begin
        s1_mag_r[l] <= s1_mag_nxt[l];
        s1_neg_r[l] <= s1_neg_nxt[l];
        s1_y_r[l]   <= s1_y_nxt[l];
      end
      if (en[1]) begin
        s2_mag_r[l] <= s1_mag_r[l];
        s2_neg_r[l] <= s1_neg_r[l];
        s2_tsq_r[l] <= {7'd0, s1_mag_r[l]} * {7'd0, s1_mag_r[l]};
        s2_ysq_r[l] <= {7'd0, s1_y_r[l]} * {7'd0, s1_y_r[l]};
      end
      if (en[2]) begin
        s3_mag_r[l] <= s2_mag_r[l];
        s3_neg_r[l] <= s2_neg_r[l];
        s3_num_r[l] <= s3_num_nxt[l][19:0];
        s3_ysq_r[l] <= s2_ysq_r[l];
      end
      if (en[3]) begin
        s4_mag_r[l] <= s3_mag_r[l];
        s4_neg_r[l] <= s3_neg_r[l];
        s4_rem_r[l] <= s4_rem_nxt[l];
        s4_q_r[l]   <= s4_q_nxt[l];
        s4_ysq_r[l] <= s3_ysq_r[l];
      end
      if (en[4]) begin
        s5_mag_r[l] <= s4_mag_r[l];
        s5_neg_r[l] <= s4_neg_r[l];
        s5_rem_r[l] <= s5_rem_nxt[l];
        s5_q_r[l]   <= s5_q_nxt[l];
        s5_ysq_r[l] <= s4_ysq_r[l];
      end
      if (en[5]) begin
        s6_mag_r[l] <= s5_mag_r[l];
        s6_neg_r[l] <= s5_neg_r[l];
        s6_rem_r[l] <= s6_rem_nxt[l];
        s6_q_r[l]   <= s6_q_nxt[l];
        s6_ysq_r[l] <= s5_ysq_r[l];
      end
      if (en[6]) begin
        s7_mag_r[l]  <= s6_mag_r[l];
        s7_neg_r[l]  <= s6_neg_r[l];
        s7_term_r[l] <= s7_term_nxt[l];
      end
      if (en[7]) begin
        s8_neg_r[l]  <= s7_neg_r[l];
        s8_prod_r[l] <= {7'd0, s7_mag_r[l]} * {7'd0, s7_term_r[l]};
      end
      if (en[8]) begin
        s9_neg_r[l]  <= s8_neg_r[l];
        s9_prod_r[l] <= s8_prod_r[l];
        s9_q0_r[l]   <= div10_est(s8_prod_r[l]);
      end
      if (en[9]) begin
        s10_neg_r[l] <= s9_neg_r[l];
        s10_t_r[l]   <= div10_fix(s9_prod_r[l], s9_q0_r[l]);
      end
      if (en[10]) begin
        s11_c_r[l] <= s11_c_nxt[l];
      end
      // knot throttle: min + span * c / 1000
      if (en[11]) begin
        s12_kp_r[l] <= {10'd0, span_mag_r} * {11'd0, s11_c_r[l]};
      end
      if (en[12]) begin
        s13_kp_r[l] <= s12_kp_r[l];
        s13_q0_r[l] <= div1000_est(s12_kp_r[l]);
      end
      if (en[13]) begin
        s14_kq_r[l] <= div1000_fix(s13_kp_r[l], s13_q0_r[l]);
      end
      if (en[14]) begin
        s15_knot_r[l] <= span_neg_r ? (min_thr_r - s14_kq_r[l]) : (min_thr_r + s14_kq_r[l]);
      end
    end
  end

  // Full flag and segment offset ride along to the interpolation multiply
  always_ff @(posedge clk) begin
    if (en[0]) begin
      full_r[0] <= (in_deflection >= FULL_DEFL);
      r_r[0]    <= r_full[6:0];
    end
    for (int i = 1; i < 16; i++) begin
      if (en[i]) begin
        full_r[i] <= full_r[i-1];
        r_r[i]    <= r_r[i-1];
      end
    end
  end

  // Interpolation between the two knots, stages 16 to 20
  logic [11:0]      diff_nxt;
  logic [11:0]      diff_n;
  logic [THR_W-1:0] s16_a_r;
  logic             s16_dneg_r;
  logic [THR_W-1:0] s16_dmag_r;
  logic [THR_W-1:0] s17_a_r;
  logic             s17_dneg_r;
  logic             s17_full_r;
  logic [17:0]      s17_ip_r;
  logic [THR_W-1:0] s18_a_r;
  logic             s18_dneg_r;
  logic             s18_full_r;
  logic [17:0]      s18_ip_r;
  logic [10:0]      s18_q0_r;
  logic [THR_W-1:0] s19_a_r;
  logic             s19_dneg_r;
  logic             s19_full_r;
  logic [10:0]      s19_iq_r;
  logic [THR_W-1:0] out_thr_r;

  assign diff_nxt = {1'b0, s15_knot_r[1]} - {1'b0, s15_knot_r[0]};
  assign diff_n   = -diff_nxt;

  always_ff @(posedge clk) begin
    if (en[15]) begin
      s16_a_r    <= s15_knot_r[0];
      s16_dneg_r <= diff_nxt[11];
      s16_dmag_r <= diff_nxt[11] ? diff_n[10:0] : diff_nxt[10:0];
    end
    if (en[16]) begin
      s17_a_r    <= s16_a_r;
      s17_dneg_r <= s16_dneg_r;
      s17_full_r <= full_r[15];
      s17_ip_r   <= {11'd0, r_r[15]} * {7'd0, s16_dmag_r};
    end
    if (en[17]) begin
      s18_a_r    <= s17_a_r;
      s18_dneg_r <= s17_dneg_r;
      s18_full_r <= s17_full_r;
      s18_ip_r   <= s17_ip_r;
      s18_q0_r   <= div100_est(s17_ip_r);
    end
    if (en[18]) begin
      s19_a_r    <= s18_a_r;
      s19_dneg_r <= s18_dneg_r;
      s19_full_r <= s18_full_r;
      s19_iq_r   <= div100_fix(s18_ip_r, s18_q0_r);
    end
    if (en[19]) begin
      if (s19_full_r) begin
        out_thr_r <= max_thr_r;
      end else begin
        out_thr_r <= s19_dneg_r ? (s19_a_r - s19_iq_r) : (s19_a_r + s19_iq_r);
      end
    end
  end

  assign out_valid        = vld_r[NST-1];
  assign out_throttle     = out_thr_r;
  assign out_throttle_mid = tmid_r;

  // Expo weight never exceeds 100: divider quotient bounded by expo
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> (s7_term_r[0] <= PCT_FULL) && (s7_term_r[1] <= PCT_FULL))
    else $error("expo weight above full scale");

  // Curve value stays on the 0..1000 scale
  a_curve_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[10] |-> (s11_c_r[0] <= CURVE_TOP) && (s11_c_r[1] <= CURVE_TOP))
    else $error("curve value out of range");

  // Knot throttles lie between the limits
  a_knot_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[14] |->
      ((s15_knot_r[0] >= min_thr_r && s15_knot_r[0] <= max_thr_r) ||
       (s15_knot_r[0] <= min_thr_r && s15_knot_r[0] >= max_thr_r)) &&
      ((s15_knot_r[1] >= min_thr_r && s15_knot_r[1] <= max_thr_r) ||
       (s15_knot_r[1] <= min_thr_r && s15_knot_r[1] >= max_thr_r)))
    else $error("knot throttle outside limits");

  // Interpolated result lies between the limits
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_throttle >= min_thr_r && out_throttle <= max_thr_r) ||
      (out_throttle <= min_thr_r && out_throttle >= max_thr_r))
    else $error("throttle outside limits");

endmodule

>>> tb/sv/throttle_curve_interpolator_top_test.sv
// Self-checking testbench for throttle_curve_interpolator_top: directed and random stick samples
// across many curve settings, with an in-bench curve predictor and an in-order result scoreboard.
// Depends on tci_pkg and throttle_curve_interpolator_top.
module throttle_curve_interpolator_top_test;
  import tci_pkg::*;

  // Curve arithmetic constants, run timeout and wait lengths
  localparam int KNOT_PITCH   = 100;
  localparam int LAST_KNOT    = 9;
  localparam int FULL_STICK   = 1000;
  localparam int CURVE_SCALE  = 1000;
  localparam int PERCENT      = 100;
  localparam int TIMEOUT_NS   = 5000000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_PRE   = 24;
  localparam int SETTLE_POST  = 8;
  localparam int DRAIN_CYCLES = 30;

  // Predictor and in-order store of expected throttle results
  class throttle_scoreboard;
    typedef struct packed {
      logic [THR_W-1:0] thr;
      logic [THR_W-1:0] thr_mid;
    } throttle_pair_t;

    throttle_pair_t   pending_q[$];
    logic [PCT_W-1:0] mid_pct;
    logic [PCT_W-1:0] expo_pct;
    logic [THR_W-1:0] idle_thr;
    logic [THR_W-1:0] full_thr;
    int               errors;

    function new();
      mid_pct  = 7'd50;
      expo_pct = 7'd0;
      idle_thr = 11'd0;
      full_thr = 11'd2000;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_CURVE_MID:    mid_pct  = v[PCT_W-1:0];
        CFG_CURVE_EXPO:   expo_pct = v[PCT_W-1:0];
        CFG_MIN_THROTTLE: idle_thr = v[THR_W-1:0];
        CFG_MAX_THROTTLE: full_thr = v[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int clip_pct(logic [PCT_W-1:0] v);
      return (int'(v) > PERCENT) ? PERCENT : int'(v);
    endfunction

    // Throttle at knot k; all divisions truncate toward zero
    function int knot_throttle(int k);
      int mid;
      int expo;
      int lo;
      int hi;
      int dev;
      int span;
      int c;
      mid  = clip_pct(mid_pct);
      expo = clip_pct(expo_pct);
      lo   = int'(idle_thr);
      hi   = int'(full_thr);
      dev  = 10 * k - mid;
      span = 1;
      if (dev > 0) span = PERCENT - mid;
      if (dev < 0) span = mid;
      if (span == 0) span = 1;
      c = 10 * mid + dev * (PERCENT - expo + expo * (dev * dev) / (span * span)) / 10;
      return lo + (hi - lo) * c / CURVE_SCALE;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Accepted input transfer: work out the result it must produce
    function void note_deflection(logic [DEFL_W-1:0] defl);
      int d;
      int seg;
      int a;
      int b;
      int thr;
      int tmid;
      throttle_pair_t e;
      d = int'(defl);
      if (d >= FULL_STICK) begin
        thr = int'(full_thr);
      end else begin
        seg = d / KNOT_PITCH;
        if (seg > LAST_KNOT) seg = LAST_KNOT;
        a   = knot_throttle(seg);
        b   = knot_throttle(seg + 1);
        thr = a + (d - seg * KNOT_PITCH) * (b - a) / KNOT_PITCH;
      end
      tmid = int'(idle_thr) + (int'(full_thr) - int'(idle_thr)) * clip_pct(mid_pct) / PERCENT;
      e.thr     = thr[THR_W-1:0];
      e.thr_mid = tmid[THR_W-1:0];
      pending_q.push_back(e);
    endfunction

    // Accepted output transfer: compare with the oldest expectation
    function void check_result(logic [THR_W-1:0] thr, logic [THR_W-1:0] thr_mid);
      throttle_pair_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result throttle=%0d throttle_mid=%0d", $time, thr, thr_mid);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (thr !== e.thr) begin
          $display("%0t: throttle mismatch expected %0d actual %0d", $time, e.thr, thr);
          errors++;
        end
        if (thr_mid !== e.thr_mid) begin
          $display("%0t: throttle_mid mismatch expected %0d actual %0d",
                   $time, e.thr_mid, thr_mid);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [DEFL_W-1:0] in_deflection;
  logic              out_valid;
  logic              out_ready;
  logic [THR_W-1:0]  out_throttle;
  logic [THR_W-1:0]  out_throttle_mid;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  throttle_scoreboard sb = new();
  bit steady;         // no gaps on either side
  bit long_hold_req;  // receiver to hold off for a long stretch

  throttle_curve_interpolator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_deflection    (in_deflection),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_throttle     (out_throttle),
    .out_throttle_mid (out_throttle_mid),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Percent register value, biased to the ends and to the saturated range
  function automatic logic [CFG_W-1:0] pick_pct();
    int r;
    logic [CFG_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 15)      v = 11'd0;
    else if (r < 30) v = 11'd100;
    else if (r < 40) v = 11'($urandom_range(101, 127));
    else             v = 11'($urandom_range(0, 100));
    // upper bits are not part of the register
    if ($urandom_range(0, 3) == 0) v[CFG_W-1:PCT_W] = 4'($urandom);
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 11'd0;
    if (r < 20) return 11'd2047;
    return 11'($urandom);
  endfunction

  function automatic logic [DEFL_W-1:0] pick_deflection();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 10'($urandom_range(0, 999));
    if (r < 80) return 10'($urandom_range(0, 10) * 100 + $urandom_range(0, 2) - 1);
    if (r < 90) return 10'($urandom_range(1000, 1023));
    return 10'($urandom);
  endfunction

  // One input transfer, preceded by a random gap
  task automatic send_item(input logic [DEFL_W-1:0] defl);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_deflection <= defl;
    do @(posedge clk); while (!in_ready);
    sb.note_deflection(defl);
  endtask

  task automatic send_directed();
    logic [DEFL_W-1:0] pts[$];
    pts = '{10'd0, 10'd1, 10'd50, 10'd99, 10'd100, 10'd101, 10'd250, 10'd341, 10'd499,
            10'd500, 10'd501, 10'd511, 10'd512, 10'd682, 10'd750, 10'd899, 10'd900,
            10'd901, 10'd950, 10'd998, 10'd999, 10'd1000, 10'd1001, 10'd1022, 10'd1023};
    foreach (pts[i]) send_item(pts[i]);
    in_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(pick_deflection());
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Reprogram the curve once the pipeline is empty, then let derived values settle
  task automatic apply_settings(input logic [CFG_W-1:0] mid_w, input logic [CFG_W-1:0] expo_w,
                                input logic [CFG_W-1:0] lo_w, input logic [CFG_W-1:0] hi_w);
    wait_drained();
    repeat (SETTLE_PRE) @(posedge clk);
    write_reg(CFG_CURVE_MID, mid_w);
    write_reg(CFG_CURVE_EXPO, expo_w);
    write_reg(CFG_MIN_THROTTLE, lo_w);
    write_reg(CFG_MAX_THROTTLE, hi_w);
    cfg_wr_en <= 1'b0;
    repeat (SETTLE_POST) @(posedge clk);
  endtask

  // Receiver: checks each output transfer and stalls at random
  initial begin
    int hold_cnt;
    bit hold_taken;
    hold_cnt   = 0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_throttle, out_throttle_mid);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        hold_cnt = pick_gap();
        out_ready <= 1'b0;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_deflection <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= CFG_CURVE_MID;
    cfg_wdata     <= '0;
    steady        = 1'b0;
    long_hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, then extreme and saturated curves
    send_directed();
    apply_settings(11'd0, 11'd0, 11'd0, 11'd2047);
    send_directed();
    apply_settings(11'd100, 11'd100, 11'd2047, 11'd0);
    steady = 1'b1;
    send_directed();
    steady = 1'b0;
    apply_settings(11'd127, 11'd127, 11'd0, 11'd2047);
    send_directed();

    // Mid point at or next to the ends, full and zero expo
    apply_settings(11'd1, 11'd100, 11'd100, 11'd1900);
    send_random(60);
    apply_settings(11'd99, 11'd100, 11'd1900, 11'd100);
    send_random(60);
    apply_settings(11'd0, 11'd100, 11'd2047, 11'd2047);
    send_random(60);
    apply_settings(11'd100, 11'd0, 11'd300, 11'd1700);
    send_random(60);

    // Output held off while input keeps coming: pipeline fills and back-pressures
    apply_settings(11'd50, 11'd60, 11'd1000, 11'd2000);
    steady = 1'b1;
    long_hold_req = 1'b1;
    send_random(100);
    steady = 1'b0;

    // Random curves
    for (int p = 0; p < 13; p++) begin
      apply_settings(pick_pct(), pick_pct(), pick_limit(), pick_limit());
      steady = ($urandom_range(0, 3) == 0);
      send_random(100);
      steady = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
